/* rtl/vbs_pkg.sv */
package vbs_pkg;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_DIVIDE,
        ST_SCAN,
        ST_ROOT,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic store;
        logic drop;
        logic clear;
        logic div_start;
        logic scan_start;
        logic scan_step;
        logic root_start;
        logic root_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic root_done;
        logic full;
    } stat_t;

endpackage

/* rtl/vbs_ctrl.sv */
module vbs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic           in_last,
    input  logic           out_busy,
    input  vbs_pkg::stat_t stat,
    output logic           in_ready,
    output vbs_pkg::cmd_t  cmd
);

    vbs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vbs_pkg::ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            vbs_pkg::ST_COLLECT: begin
                in_ready  = 1'b1;
                cmd.store = in_fire && !stat.full;
                cmd.drop  = in_fire && stat.full;
                if (in_fire && in_last) begin
                    cmd.div_start = 1'b1;
                    state_next    = vbs_pkg::ST_DIVIDE;
                end
            end
            vbs_pkg::ST_DIVIDE: begin
                if (stat.div_done) begin
                    cmd.scan_start = 1'b1;
                    state_next     = vbs_pkg::ST_SCAN;
                end
            end
            vbs_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    cmd.root_start = 1'b1;
                    state_next     = vbs_pkg::ST_ROOT;
                end
            end
            vbs_pkg::ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (stat.root_done) begin
                    state_next = vbs_pkg::ST_OUTPUT;
                end
            end
            vbs_pkg::ST_OUTPUT: begin
                if (!out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = vbs_pkg::ST_COLLECT;
                end
            end
            default: begin
                state_next = vbs_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

/* rtl/vbs_datapath.sv */
module vbs_datapath #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vbs_pkg::cmd_t         cmd,
    input  logic [COORD_BITS-1:0] in_x,
    input  logic [COORD_BITS-1:0] in_y,
    input  logic [COORD_BITS-1:0] in_z,
    output vbs_pkg::stat_t        stat,
    output logic [23:0]           cx_out,
    output logic [23:0]           cy_out,
    output logic [23:0]           cz_out,
    output logic [24:0]           radius_out,
    output logic [10:0]           total_out,
    output logic                  drop_in
);

    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int SW  = COORD_BITS + CW + 1;
    localparam int DW  = COORD_BITS + 2;
    localparam int QW  = 2 * DW + 2;
    localparam int RW  = QW / 2 + 1;
    localparam int DVC = $clog2(SW + 1);

    logic [3*COORD_BITS-1:0] mem [MAX_VERTICES];
    logic [3*COORD_BITS-1:0] rd_reg;

    logic signed [SW-1:0] sx_reg, sy_reg, sz_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 drop_reg;

    assign stat.full = (cnt_reg == CW'(MAX_VERTICES));
    assign drop_in   = drop_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[cnt_reg[AW-1:0]] <= {in_z, in_y, in_x};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            sx_reg   <= '0;
            sy_reg   <= '0;
            sz_reg   <= '0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else if (cmd.store) begin
            sx_reg  <= sx_reg + SW'($signed(in_x));
            sy_reg  <= sy_reg + SW'($signed(in_y));
            sz_reg  <= sz_reg + SW'($signed(in_z));
            cnt_reg <= cnt_reg + 1'b1;
        end else if (cmd.drop) begin
            drop_reg <= 1'b1;
        end
    end

    // three restoring dividers on magnitudes, one quotient bit a cycle
    logic [SW-1:0]  rem_reg [3];
    logic [SW-1:0]  quo_reg [3];
    logic [2:0]     neg_reg;
    logic [DVC-1:0] dcnt_reg;
    logic           dbusy_reg;
    logic           dload_reg;
    logic signed [SW-1:0] sums [3];
    logic signed [COORD_BITS:0] cen [3];

    assign sums[0] = sx_reg;
    assign sums[1] = sy_reg;
    assign sums[2] = sz_reg;
    assign stat.div_done = dbusy_reg && (dcnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dload_reg <= 1'b0;
        end else begin
            dload_reg <= cmd.div_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else if (dload_reg) begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= DVC'(SW);
            for (int k = 0; k < 3; k++) begin
                neg_reg[k] <= sums[k][SW-1];
                quo_reg[k] <= sums[k][SW-1] ? -sums[k] : sums[k];
                rem_reg[k] <= '0;
            end
        end else if (dbusy_reg) begin
            if (dcnt_reg == '0) begin
                dbusy_reg <= 1'b0;
            end else begin
                dcnt_reg <= dcnt_reg - 1'b1;
                for (int k = 0; k < 3; k++) begin
                    logic [SW:0] t;
                    t = {rem_reg[k], quo_reg[k][SW-1]};
                    if (t >= (SW+1)'(cnt_reg)) begin
                        rem_reg[k] <= SW'(t - (SW+1)'(cnt_reg));
                        quo_reg[k] <= {quo_reg[k][SW-2:0], 1'b1};
                    end else begin
                        rem_reg[k] <= SW'(t);
                        quo_reg[k] <= {quo_reg[k][SW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cen[k] = neg_reg[k] ? -$signed(quo_reg[k][COORD_BITS:0])
                                : $signed(quo_reg[k][COORD_BITS:0]);
        end
    end

    // scan: read, difference/square, sum/compare
    logic [CW-1:0] rdi_reg;
    logic          v0_reg, v1_reg, v2_reg;
    logic [2*DW-1:0] sq_reg [3];
    logic [QW-1:0]   max_reg;
    logic signed [DW-1:0] dif [3];

    assign stat.scan_done = cmd.scan_step && !v0_reg && !v1_reg && !v2_reg
                            && (rdi_reg == cnt_reg);

    always_ff @(posedge aclk) begin
        if (cmd.scan_step && rdi_reg != cnt_reg) begin
            rd_reg <= mem[rdi_reg[AW-1:0]];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dif[k] = DW'($signed(rd_reg[k*COORD_BITS +: COORD_BITS])) - DW'(cen[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            rdi_reg <= '0;
            max_reg <= '0;
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end else if (cmd.scan_step) begin
            v0_reg <= (rdi_reg != cnt_reg);
            if (rdi_reg != cnt_reg) begin
                rdi_reg <= rdi_reg + 1'b1;
            end
            v1_reg <= v0_reg;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= (2*DW)'(dif[k] * dif[k]);
            end
            v2_reg <= v1_reg;
            if (v1_reg) begin
                logic [QW-1:0] d;
                d = QW'(sq_reg[0]) + QW'(sq_reg[1]) + QW'(sq_reg[2]);
                if (d > max_reg) begin
                    max_reg <= d;
                end
            end
        end
    end

    // digit-by-digit square root, two radicand bits a cycle
    logic [QW+1:0] rn_reg;
    logic [RW-1:0] rr_reg;
    logic [RW+1:0] rm_reg;
    logic [$clog2(RW+1)-1:0] rc_reg;

    assign stat.root_done = cmd.root_step && (rc_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.root_start) begin
            rn_reg <= (QW+2)'(max_reg);
            rr_reg <= '0;
            rm_reg <= '0;
            rc_reg <= ($clog2(RW+1))'((QW + 2) / 2);
        end else if (cmd.root_step && rc_reg != '0) begin
            logic [RW+1:0] t;
            logic [RW+1:0] rem;
            rem = {rm_reg[RW-1:0], rn_reg[QW+1:QW]};
            t   = {rr_reg, 2'b01};
            rn_reg <= {rn_reg[QW-1:0], 2'b00};
            rc_reg <= rc_reg - 1'b1;
            if (rem >= t) begin
                rm_reg <= rem - t;
                rr_reg <= {rr_reg[RW-2:0], 1'b1};
            end else begin
                rm_reg <= rem;
                rr_reg <= {rr_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign cx_out     = 24'(cen[0]);
    assign cy_out     = 24'(cen[1]);
    assign cz_out     = 24'(cen[2]);
    assign radius_out = 25'(rr_reg);
    assign total_out  = 11'(cnt_reg);

endmodule

/* rtl/vertex_bounding_sphere.sv */
// Centroid bounding sphere of a vertex stream.
// Slave channel: one vertex per transaction; tdata carries x, y, z
// (COORD_BITS each, signed Q12.12), tlast marks the final vertex.
// Master channel: one result per model after the last vertex.
// Each vertex is stored and summed as it is accepted; extra vertices beyond
// MAX_VERTICES are dropped and flagged.
// After tlast: serial division of the sums (SW = COORD_BITS +
// clog2(MAX_VERTICES+1) + 1 quotient bits), a distance scan over the single
// read port of the vertex memory, and COORD_BITS+4 root steps.
// s_tready is low from the last vertex until the result is loaded.
// The result register holds while m_tready is low; the next model
// may be collected while it waits, but its result waits for it.
// Reset clears sums, counts and control; the memory needs no clearing.
module vertex_bounding_sphere #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [3*COORD_BITS-1:0] s_tdata, // x_coord, y_coord, z_coord
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata, // center_x, center_y, center_z, radius, vertex_total
    output logic          m_tuser  // overflowed
);

    vbs_pkg::cmd_t  cmd;
    vbs_pkg::stat_t stat;
    logic in_fire;
    logic [23:0] cx, cy, cz;
    logic [24:0] rad;
    logic [10:0] tot;
    logic drop;
    logic [111:0] data_reg;
    logic         user_reg;
    logic         valid_reg;

    assign in_fire = s_tvalid && s_tready;

    vbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_last  (s_tlast),
        .out_busy (valid_reg && !m_tready),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    vbs_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_x       (s_tdata[COORD_BITS-1:0]),
        .in_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_z       (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .stat       (stat),
        .cx_out     (cx),
        .cy_out     (cy),
        .cz_out     (cz),
        .radius_out (rad),
        .total_out  (tot),
        .drop_in    (drop)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            data_reg <= {4'b0, tot, rad, cz, cy, cx};
            user_reg <= drop;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

/* rtl/vbs_checker.sv */
module vbs_props (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_last_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during finish");

    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[107:97] != 11'd0)
        else $error("zero vertex total");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid after reset");

endmodule

bind vertex_bounding_sphere vbs_props u_vbs_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
